/* sv/i2crts_pkg.sv */
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types, codes and helpers of the i2c register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

  // default width of the byte counters
  localparam int COUNT_BITS_DEF = 16;

  // widths of the item fields
  localparam int FUNC_W   = 3;
  localparam int DEV_W    = 7;
  localparam int REG_W    = 16;
  localparam int RBYTES_W = 2;
  localparam int LEN_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int PHASE_W  = 3;

  // event codes on the func field
  localparam logic [FUNC_W-1:0] FUNC_START    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_TX_READY = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RX_BYTE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_NACK     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ARB_LOST = 3'd4;

  // phase codes as reported in the result item
  localparam logic [PHASE_W-1:0] PHC_IDLE   = 3'd0;
  localparam logic [PHASE_W-1:0] PHC_REG    = 3'd1;
  localparam logic [PHASE_W-1:0] PHC_SWITCH = 3'd2;
  localparam logic [PHASE_W-1:0] PHC_TXDATA = 3'd3;
  localparam logic [PHASE_W-1:0] PHC_RXDATA = 3'd4;

  // register address byte handling
  localparam logic [RBYTES_W-1:0] REG_BYTES_MAX = 2'd2;
  localparam logic [REG_W-1:0]    ADDR_HI_MASK  = 16'hFF00;
  localparam logic [REG_W-1:0]    ADDR_LO_MASK  = 16'h00FF;
  localparam int                  BYTE_SHIFT    = 8;

  // sequencer state, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_REG    = 5'b00010,
    PH_SWITCH = 5'b00100,
    PH_TXDATA = 5'b01000,
    PH_RXDATA = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [DEV_W-1:0]    target_addr;
    logic [REG_W-1:0]    reg_addr;
    logic [RBYTES_W-1:0] reg_bytes;
    logic                is_read;
    logic [LEN_W-1:0]    length;
    logic                keep_bus;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   rx_byte;
  } in_item_t;

  typedef struct packed {
    logic               send_valid;
    logic [BYTE_W-1:0]  send_byte;
    logic               data_taken;
    logic               send_start;
    logic               send_stop;
    logic               to_receiver;
    logic               recv_valid;
    logic [BYTE_W-1:0]  recv_byte;
    logic               done_res;
    logic [PHASE_W-1:0] phase;
    logic               nack_seen;
    logic [DEV_W-1:0]   slave_address;
  } out_item_t;

  // one-hot state to reported phase code
  function automatic logic [PHASE_W-1:0] phase_code(input phase_e ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:   code = PHC_IDLE;
      PH_REG:    code = PHC_REG;
      PH_SWITCH: code = PHC_SWITCH;
      PH_TXDATA: code = PHC_TXDATA;
      PH_RXDATA: code = PHC_RXDATA;
      default:   code = PHC_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* sv/i2crts_if.sv */
// ----------------------------------------------------------------------------
// i2crts channel interfaces
// Valid/ready channels carrying bus events in and sequencer results out.
// ----------------------------------------------------------------------------
interface i2crts_in_if import i2crts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface i2crts_out_if import i2crts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/i2crts_in_reg.sv */
// ----------------------------------------------------------------------------
// i2crts_in_reg
// Input register: holds one event item until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2crts_in_reg import i2crts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2crts_in_if.sink in_i,
  input  logic      adv_i,
  output logic      valid_o,
  output in_item_t  item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // free when empty or when the held item moves on this cycle
  assign in_i.ready = !valid_q || adv_i;
  assign load       = in_i.valid && in_i.ready;
  assign valid_d    = in_i.ready ? in_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* sv/i2crts_seq.sv */
// ----------------------------------------------------------------------------
// i2crts_seq
// Transaction state and the per-event next-state and result logic.
// ----------------------------------------------------------------------------
module i2crts_seq import i2crts_pkg::*; #(
  parameter int CountBits = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t res_o
);

  localparam int ExtW = (CountBits > LEN_W) ? CountBits : LEN_W;

  phase_e                phase_q, phase_d;
  logic [RBYTES_W-1:0]   abl_q, abl_d;
  logic [REG_W-1:0]      raddr_q, raddr_d;
  logic [CountBits-1:0]  write_q, write_d;
  logic [CountBits-1:0]  read_q, read_d;
  logic                  no_stop_q, no_stop_d;
  logic                  nack_q, nack_d;
  logic [DEV_W-1:0]      target_q, target_d;

  logic [ExtW-1:0]       len_ext;
  logic [ExtW-1:0]       cnt_max;
  logic [CountBits-1:0]  len_cnt;
  logic [RBYTES_W-1:0]   rb_clamp;

  // saturate the requested length to the counter width
  assign len_ext  = ExtW'(item_i.length);
  assign cnt_max  = ExtW'({CountBits{1'b1}});
  assign len_cnt  = (len_ext > cnt_max) ? cnt_max[CountBits-1:0] : len_ext[CountBits-1:0];
  assign rb_clamp = (item_i.reg_bytes > REG_BYTES_MAX) ? REG_BYTES_MAX : item_i.reg_bytes;

  // next state and result for the event in the input register
  always_comb begin
    logic [CountBits-1:0] read_next;
    phase_d   = phase_q;
    abl_d     = abl_q;
    raddr_d   = raddr_q;
    write_d   = write_q;
    read_d    = read_q;
    no_stop_d = no_stop_q;
    nack_d    = nack_q;
    target_d  = target_q;
    read_next = read_q;
    res_o     = '0;

    case (item_i.func)
      FUNC_START: begin
        target_d         = item_i.target_addr;
        raddr_d          = item_i.reg_addr;
        abl_d            = rb_clamp;
        res_o.send_start = 1'b1;
        if (item_i.is_read) begin
          no_stop_d = 1'b0;
          write_d   = '0;
          read_d    = len_cnt;
          if (rb_clamp == '0) begin
            // plain read goes straight to receive
            phase_d = PH_RXDATA;
            if (len_cnt <= CountBits'(1)) begin
              res_o.send_stop = 1'b1;
            end
          end else begin
            phase_d = PH_REG;
          end
        end else begin
          no_stop_d = item_i.keep_bus;
          write_d   = len_cnt;
          read_d    = '0;
          phase_d   = (rb_clamp == '0) ? PH_TXDATA : PH_REG;
        end
      end
      FUNC_TX_READY: begin
        unique case (phase_q)
          PH_REG: begin
            res_o.send_valid = 1'b1;
            if (abl_q > RBYTES_W'(1)) begin
              res_o.send_byte = BYTE_W'((raddr_q & ADDR_HI_MASK) >> BYTE_SHIFT);
              abl_d           = abl_q - RBYTES_W'(1);
            end else begin
              res_o.send_byte = BYTE_W'(raddr_q & ADDR_LO_MASK);
              abl_d           = '0;
              phase_d         = (read_q != '0) ? PH_SWITCH : PH_TXDATA;
            end
          end
          PH_SWITCH: begin
            // repeated start, turn the bus around
            res_o.send_start = 1'b1;
            phase_d          = PH_RXDATA;
            if (read_q == CountBits'(1)) begin
              res_o.send_stop = 1'b1;
            end
          end
          PH_TXDATA: begin
            if (write_q != '0) begin
              res_o.send_valid = 1'b1;
              res_o.send_byte  = item_i.data_byte;
              res_o.data_taken = 1'b1;
              write_d          = write_q - CountBits'(1);
            end else begin
              res_o.send_stop = !no_stop_q;
              res_o.done_res  = 1'b1;
              phase_d         = PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_RX_BYTE: begin
        if (phase_q == PH_RXDATA) begin
          if (read_q != '0) begin
            res_o.recv_valid = 1'b1;
            res_o.recv_byte  = item_i.rx_byte;
            read_next        = read_q - CountBits'(1);
          end
          read_d = read_next;
          // stop goes out ahead of the last byte
          if (read_next == CountBits'(1)) begin
            res_o.send_stop = 1'b1;
          end else if (read_next == '0) begin
            res_o.done_res = 1'b1;
            phase_d        = PH_IDLE;
          end
        end
      end
      FUNC_NACK: begin
        nack_d          = 1'b1;
        res_o.send_stop = 1'b1;
        res_o.done_res  = 1'b1;
        phase_d         = PH_IDLE;
      end
      FUNC_ARB_LOST: begin
        res_o.done_res = 1'b1;
        phase_d        = PH_IDLE;
      end
      default: begin
      end
    endcase

    res_o.to_receiver   = (phase_d == PH_RXDATA);
    res_o.phase         = phase_code(phase_d);
    res_o.nack_seen     = nack_d;
    res_o.slave_address = target_d;
  end

  // transaction state, updated when the event moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      abl_q     <= '0;
      raddr_q   <= '0;
      write_q   <= '0;
      read_q    <= '0;
      no_stop_q <= 1'b0;
      nack_q    <= 1'b0;
      target_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      abl_q     <= abl_d;
      raddr_q   <= raddr_d;
      write_q   <= write_d;
      read_q    <= read_d;
      no_stop_q <= no_stop_d;
      nack_q    <= nack_d;
      target_q  <= target_d;
    end
  end

endmodule

/* sv/i2crts_out_reg.sv */
// ----------------------------------------------------------------------------
// i2crts_out_reg
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module i2crts_out_reg import i2crts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  out_item_t     res_i,
  output logic          space_o,
  i2crts_out_if.source  out_o
);

  logic      valid_q, valid_d;
  out_item_t res_q;

  // room for a new result when empty or when the held one leaves now
  assign space_o = !valid_q || out_o.ready;
  assign valid_d = load_i ? 1'b1 : (out_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid   = valid_q;
  assign out_o.payload = res_q;

endmodule

/* sv/i2c_register_transaction_sequencer_core.sv */
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer_core
// Steps an i2c master through register read and write transactions.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries bus events (start, tx ready, byte received, nack, arbitration
//   lost); out_o carries exactly one result item per event, telling
//   the byte engine what to send, whether to issue start or stop, and the
//   transaction phase, sticky nack flag and slave address.
//   An accepted event sits in the input register while the sequencer logic
//   evaluates it; the result register loads the result when it has room,
//   and the result is offered on out_o from that register until taken.
//   Throughput is one event per cycle while out_o is not stalled; the
//   transaction state updates through next-state logic between the two
//   registers.
//   When out_o is stalled the result register holds, the input register
//   still takes one more event, and in_i.ready then drops until the result
//   is taken. Nothing is dropped or repeated.
//   Reset puts the sequencer idle with all counters, the register address,
//   the slave address and the nack flag at zero, and empties both registers.
//   The nack flag is cleared only by reset.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer_core import i2crts_pkg::*; #(
  parameter int CountBits = COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2crts_in_if.sink    in_i,
  i2crts_out_if.source out_o
);

  logic      held_valid;
  in_item_t  held_item;
  logic      out_space;
  logic      adv;
  out_item_t res;

  // event moves from input register to result register
  assign adv = held_valid && out_space;

  i2crts_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (adv),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  i2crts_seq #(
    .CountBits (CountBits)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .item_i (held_item),
    .res_o  (res)
  );

  i2crts_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (res),
    .space_o (out_space),
    .out_o   (out_o)
  );

  // a finished or aborted transaction always reports idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.done_res |-> out_o.payload.phase == PHC_IDLE)
    else $error("done result with non-idle phase");

  // direction follows the reported phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.payload.to_receiver == (out_o.payload.phase == PHC_RXDATA))
    else $error("to_receiver disagrees with phase");

  // nack flag never falls back once reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && out_o.payload.nack_seen
      |=> !out_o.valid || out_o.payload.nack_seen)
    else $error("sticky nack flag cleared");

  // no send and receive of a byte from the same event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.payload.send_valid && out_o.payload.recv_valid))
    else $error("send and receive in one result");

  // idle bytes read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.payload.send_valid |-> out_o.payload.send_byte == '0)
    else $error("send_byte set without send_valid");

endmodule
